// ----- design/priority_status_led_pulser_core_defines.svh -----
// assertion macros shared by the pulser rtl
`ifndef PRIORITY_STATUS_LED_PULSER_CORE_DEFINES_SVH
`define PRIORITY_STATUS_LED_PULSER_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define PSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define PSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/psl_pkg.sv -----
package psl_pkg;

    // event kinds
    localparam logic [1:0] KIND_LED_REPORT = 2'd0;
    localparam logic [1:0] KIND_BATTERY    = 2'd1;
    localparam logic [1:0] KIND_ACTIVITY   = 2'd2;
    localparam logic [1:0] KIND_TICK       = 2'd3;

    // result commands
    localparam logic CMD_SOLID   = 1'b0;
    localparam logic CMD_RESTORE = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_CRITICAL_PERCENT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_PERCENT        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_ON_MS        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_PERIOD_MS      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CRITICAL_PERIOD_MS = 3'd4;

    // register reset values
    localparam logic [6:0]  RST_CRITICAL_PERCENT   = 7'd10;
    localparam logic [6:0]  RST_LOW_PERCENT        = 7'd20;
    localparam logic [15:0] RST_PULSE_ON_MS        = 16'd120;
    localparam logic [15:0] RST_LOW_PERIOD_MS      = 16'd3000;
    localparam logic [15:0] RST_CRITICAL_PERIOD_MS = 16'd1500;

    // colour constants
    localparam int unsigned CAPS_BIT   = 1;
    localparam logic [8:0]  HUE_RED    = 9'd0;
    localparam logic [8:0]  HUE_ORANGE = 9'd30;
    localparam logic [6:0]  FULL_PCT   = 7'd100;

    typedef enum logic [1:0] {
        CHARGE_OK       = 2'd0,
        CHARGE_LOW      = 2'd1,
        CHARGE_CRITICAL = 2'd2
    } batt_mode_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] led_report;
        logic [6:0] charge_percent;
        logic       now_active;
        logic       user_strip_on;
    } psl_in_t;

    typedef struct packed {
        logic       command;
        logic [8:0] hue;
        logic [6:0] saturation;
        logic [6:0] brightness;
        logic       power_on;
    } psl_out_t;

endpackage

// ----- design/priority_status_led_pulser_core.sv -----
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+----------------------------
// in        | input     | in_valid / in_ready   | in_data (psl_in_t)
// out       | output    | out_valid / out_ready | out_data (psl_out_t)
// cfg       | input     | cfg_write_en only     | cfg_index, cfg_data
//
// one event is taken per cycle while in_ready is high; its result, if any, shows on out in the next cycle
// the state update and result selection are combinational logic ahead of the output register
// in_ready is low only while the output register holds a result that out does not take
// rst_n resets status (active flag set, others cleared), clears timer and output valid and loads the register defaults

`include "priority_status_led_pulser_core_defines.svh"

module priority_status_led_pulser_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  psl_pkg::psl_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output psl_pkg::psl_out_t                   out_data,
    input  logic                                cfg_write_en,
    input  logic [psl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [psl_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import psl_pkg::*;

    // configuration registers
    logic [6:0]  critical_percent_reg;
    logic [6:0]  low_percent_reg;
    logic [15:0] pulse_on_ms_reg;
    logic [15:0] low_period_ms_reg;
    logic [15:0] critical_period_ms_reg;

    // status and timer state
    logic        caps_flag_reg,     caps_flag_next;
    batt_mode_t  battery_mode_reg,  battery_mode_next;
    logic        active_flag_reg,   active_flag_next;
    logic        override_flag_reg, override_flag_next;
    logic        saved_user_on_reg, saved_user_on_next;
    logic        pulse_lit_reg,     pulse_lit_next;
    logic        timer_armed_reg,   timer_armed_next;
    logic [15:0] timer_count_reg,   timer_count_next;

    // output register
    logic        out_valid_reg;
    psl_out_t    out_data_reg;

    logic        in_xfer;
    logic        do_settle;
    logic        res_valid;
    psl_out_t    res;
    batt_mode_t  charge_mode;
    logic        caps_bit;
    logic        crit_now;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign caps_bit = in_data.led_report[CAPS_BIT];
    assign crit_now = (battery_mode_reg == CHARGE_CRITICAL);

    // battery mode from charge, critical compare first
    always_comb
    begin
        priority if (in_data.charge_percent <= critical_percent_reg)
            charge_mode = CHARGE_CRITICAL;
        else if (in_data.charge_percent <= low_percent_reg)
            charge_mode = CHARGE_LOW;
        else
            charge_mode = CHARGE_OK;
    end

    // event decode, settle and timer expiry
    always_comb
    begin
        caps_flag_next     = caps_flag_reg;
        battery_mode_next  = battery_mode_reg;
        active_flag_next   = active_flag_reg;
        override_flag_next = override_flag_reg;
        saved_user_on_next = saved_user_on_reg;
        pulse_lit_next     = pulse_lit_reg;
        timer_armed_next   = timer_armed_reg;
        timer_count_next   = timer_count_reg;
        do_settle          = 1'b0;
        res_valid          = 1'b0;
        res                = '0;

        unique case (in_data.kind)
            KIND_LED_REPORT:
            begin
                if (caps_bit != caps_flag_reg)
                begin
                    caps_flag_next = caps_bit;
                    do_settle      = 1'b1;
                end
            end
            KIND_BATTERY:
            begin
                if (charge_mode != battery_mode_reg)
                begin
                    battery_mode_next = charge_mode;
                    do_settle         = 1'b1;
                end
            end
            KIND_ACTIVITY:
            begin
                if (in_data.now_active != active_flag_reg)
                begin
                    active_flag_next = in_data.now_active;
                    do_settle        = 1'b1;
                end
            end
            default:
            begin
                // millisecond tick
                if (timer_armed_reg)
                begin
                    if (timer_count_reg <= 16'd1)
                    begin
                        timer_armed_next = 1'b0;
                        if (active_flag_reg &&
                            (battery_mode_reg == CHARGE_LOW || crit_now))
                        begin
                            res_valid        = 1'b1;
                            res.command      = CMD_SOLID;
                            res.power_on     = 1'b1;
                            timer_armed_next = 1'b1;
                            if (pulse_lit_reg)
                            begin
                                // lit phase over: go dark for the gap
                                pulse_lit_next   = 1'b0;
                                timer_count_next = crit_now ? critical_period_ms_reg
                                                            : low_period_ms_reg;
                            end
                            else
                            begin
                                pulse_lit_next   = 1'b1;
                                timer_count_next = pulse_on_ms_reg;
                                res.hue          = crit_now ? HUE_RED : HUE_ORANGE;
                                res.saturation   = FULL_PCT;
                                res.brightness   = FULL_PCT;
                            end
                        end
                    end
                    else
                    begin
                        timer_count_next = timer_count_reg - 16'd1;
                    end
                end
            end
        endcase

        // re-evaluate the look after a status change
        if (do_settle)
        begin
            if (!active_flag_next)
            begin
                timer_armed_next = 1'b0;
            end
            else if (battery_mode_next == CHARGE_LOW || battery_mode_next == CHARGE_CRITICAL)
            begin
                if (!override_flag_reg)
                begin
                    saved_user_on_next = in_data.user_strip_on;
                    override_flag_next = 1'b1;
                end
                pulse_lit_next   = 1'b0;
                timer_armed_next = 1'b1;
                timer_count_next = '0;
            end
            else if (caps_flag_next)
            begin
                if (!override_flag_reg)
                begin
                    saved_user_on_next = in_data.user_strip_on;
                    override_flag_next = 1'b1;
                end
                timer_armed_next = 1'b0;
                res_valid        = 1'b1;
                res.command      = CMD_SOLID;
                res.brightness   = FULL_PCT;
                res.power_on     = 1'b1;
            end
            else
            begin
                timer_armed_next = 1'b0;
                if (override_flag_reg)
                begin
                    override_flag_next = 1'b0;
                    res_valid          = 1'b1;
                    res.command        = CMD_RESTORE;
                    res.power_on       = saved_user_on_reg;
                end
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            critical_percent_reg   <= RST_CRITICAL_PERCENT;
            low_percent_reg        <= RST_LOW_PERCENT;
            pulse_on_ms_reg        <= RST_PULSE_ON_MS;
            low_period_ms_reg      <= RST_LOW_PERIOD_MS;
            critical_period_ms_reg <= RST_CRITICAL_PERIOD_MS;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_CRITICAL_PERCENT:   critical_percent_reg   <= cfg_data[6:0];
                REG_LOW_PERCENT:        low_percent_reg        <= cfg_data[6:0];
                REG_PULSE_ON_MS:        pulse_on_ms_reg        <= cfg_data;
                REG_LOW_PERIOD_MS:      low_period_ms_reg      <= cfg_data;
                REG_CRITICAL_PERIOD_MS: critical_period_ms_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caps_flag_reg     <= 1'b0;
            battery_mode_reg  <= CHARGE_OK;
            active_flag_reg   <= 1'b1;
            override_flag_reg <= 1'b0;
            saved_user_on_reg <= 1'b0;
            pulse_lit_reg     <= 1'b0;
            timer_armed_reg   <= 1'b0;
            timer_count_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                caps_flag_reg     <= caps_flag_next;
                battery_mode_reg  <= battery_mode_next;
                active_flag_reg   <= active_flag_next;
                override_flag_reg <= override_flag_next;
                saved_user_on_reg <= saved_user_on_next;
                pulse_lit_reg     <= pulse_lit_next;
                timer_armed_reg   <= timer_armed_next;
                timer_count_reg   <= timer_count_next;
            end
            if (in_xfer && res_valid)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer && res_valid)
            out_data_reg <= res;
    end

    // checks
    `PSL_ASSERT_NOW(a_stall_blocks_input, out_valid_reg && !out_ready, !in_ready,
        "input taken while a stalled result is held")
    `PSL_ASSERT_NOW(a_timer_only_when_pulsing, timer_armed_reg,
        active_flag_reg && battery_mode_reg != CHARGE_OK,
        "pulse timer armed while idle or battery ok")
    `PSL_ASSERT_NOW(a_release_restores, $fell(override_flag_reg),
        out_valid_reg && out_data_reg.command == CMD_RESTORE,
        "override released without a restore result")

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import psl_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    psl_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    psl_out_t out_data;
    logic cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // events waiting to be driven and looks waiting to come out
    psl_in_t event_q[$];
    psl_out_t look_q[$];
    int unsigned mismatch_count = 0;

    // shadow of the configuration registers
    logic [6:0] cfg_crit_pct;
    logic [6:0] cfg_low_pct;
    logic [15:0] cfg_pulse_on;
    logic [15:0] cfg_low_gap;
    logic [15:0] cfg_crit_gap;

    // predicted strip status
    logic st_caps;
    batt_mode_t st_mode;
    logic st_active;
    logic st_override;
    logic st_saved_on;
    logic st_lit;
    logic st_armed;
    logic [15:0] st_count;

    priority_status_led_pulser_core dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #10000000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic void timer_start(input logic [15:0] delay);
        st_armed = 1'b1;
        st_count = delay;
    endfunction

    // remember the user's on/off state on the first takeover only
    function automatic void take_strip(input logic user_on);
        if (!st_override)
        begin
            st_saved_on = user_on;
            st_override = 1'b1;
        end
    endfunction

    // pick the look after a status change, highest priority first
    function automatic bit resolve_look(input logic user_on, output psl_out_t res);
        res = '0;
        if (!st_active)
        begin
            st_armed = 1'b0;
            return 1'b0;
        end
        if (st_mode == CHARGE_LOW || st_mode == CHARGE_CRITICAL)
        begin
            take_strip(user_on);
            st_lit = 1'b0;
            timer_start(16'd0);
            return 1'b0;
        end
        if (st_caps)
        begin
            take_strip(user_on);
            st_armed = 1'b0;
            res.command = CMD_SOLID;
            res.brightness = FULL_PCT;
            res.power_on = 1'b1;
            return 1'b1;
        end
        st_armed = 1'b0;
        if (st_override)
        begin
            st_override = 1'b0;
            res.command = CMD_RESTORE;
            res.power_on = st_saved_on;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the status by one event; returns 1 when a look comes out
    function automatic bit strip_update(input psl_in_t ev, output psl_out_t res);
        logic caps;
        batt_mode_t mode;
        logic crit;
        res = '0;
        case (ev.kind)
            KIND_LED_REPORT:
            begin
                caps = ev.led_report[CAPS_BIT];
                if (caps == st_caps)
                    return 1'b0;
                st_caps = caps;
                return resolve_look(ev.user_strip_on, res);
            end
            KIND_BATTERY:
            begin
                if (ev.charge_percent <= cfg_crit_pct)
                    mode = CHARGE_CRITICAL;
                else if (ev.charge_percent <= cfg_low_pct)
                    mode = CHARGE_LOW;
                else
                    mode = CHARGE_OK;
                if (mode == st_mode)
                    return 1'b0;
                st_mode = mode;
                return resolve_look(ev.user_strip_on, res);
            end
            KIND_ACTIVITY:
            begin
                if (ev.now_active == st_active)
                    return 1'b0;
                st_active = ev.now_active;
                return resolve_look(ev.user_strip_on, res);
            end
            default:
            begin
                if (!st_armed)
                    return 1'b0;
                if (st_count > 16'd1)
                begin
                    st_count = st_count - 16'd1;
                    return 1'b0;
                end
                // pulse timer expiry: toggle lit and dark
                crit = (st_mode == CHARGE_CRITICAL);
                st_armed = 1'b0;
                if (!st_active || (st_mode != CHARGE_LOW && !crit))
                    return 1'b0;
                res.power_on = 1'b1;
                if (st_lit)
                begin
                    st_lit = 1'b0;
                    timer_start(crit ? cfg_crit_gap : cfg_low_gap);
                    return 1'b1;
                end
                st_lit = 1'b1;
                timer_start(cfg_pulse_on);
                res.hue = crit ? HUE_RED : HUE_ORANGE;
                res.saturation = FULL_PCT;
                res.brightness = FULL_PCT;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void push_event(input logic [1:0] kind, input logic [7:0] report,
                                       input logic [6:0] charge, input logic act,
                                       input logic user_on);
        psl_in_t ev;
        ev.kind = kind;
        ev.led_report = report;
        ev.charge_percent = charge;
        ev.now_active = act;
        ev.user_strip_on = user_on;
        event_q.push_back(ev);
    endfunction

    // random event, charges clustered around the thresholds
    function automatic psl_in_t random_event();
        psl_in_t ev;
        int unsigned pick;
        int c;
        pick = $urandom_range(0, 99);
        ev.led_report = 8'($urandom_range(0, 255));
        ev.now_active = ($urandom_range(0, 3) != 0);
        ev.user_strip_on = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: c = int'($urandom_range(0, 100));
            1: c = int'(cfg_crit_pct) + int'($urandom_range(0, 2)) - 1;
            2: c = int'(cfg_low_pct) + int'($urandom_range(0, 2)) - 1;
            default: c = int'($urandom_range(21, 100));
        endcase
        if (c < 0)
            c = 0;
        if (c > 100)
            c = 100;
        ev.charge_percent = 7'(c);
        if (pick < 55)
            ev.kind = KIND_TICK;
        else if (pick < 70)
            ev.kind = KIND_BATTERY;
        else if (pick < 85)
            ev.kind = KIND_LED_REPORT;
        else
            ev.kind = KIND_ACTIVITY;
        return ev;
    endfunction

    // write all registers, one per cycle, and mirror them
    task automatic apply_setting(input int unsigned crit_pct, input int unsigned low_pct,
                                 input int unsigned on_ms, input int unsigned low_gap,
                                 input int unsigned crit_gap);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [CFG_INDEX_W-1:0] idxs [5];
        vals[0] = 16'(crit_pct);
        vals[1] = 16'(low_pct);
        vals[2] = 16'(on_ms);
        vals[3] = 16'(low_gap);
        vals[4] = 16'(crit_gap);
        idxs[0] = REG_CRITICAL_PERCENT;
        idxs[1] = REG_LOW_PERCENT;
        idxs[2] = REG_PULSE_ON_MS;
        idxs[3] = REG_LOW_PERIOD_MS;
        idxs[4] = REG_CRITICAL_PERIOD_MS;
        for (int i = 0; i < 5; i++)
        begin
            @(posedge clk);
            cfg_write_en <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data <= vals[i];
        end
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cfg_crit_pct = vals[0][6:0];
        cfg_low_pct = vals[1][6:0];
        cfg_pulse_on = vals[2];
        cfg_low_gap = vals[3];
        cfg_crit_gap = vals[4];
    endtask

    // wait until every event is taken and every look has arrived
    task automatic wait_idle();
        do
            @(posedge clk);
        while (event_q.size() != 0 || in_valid || look_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // event driver: bursts with random gaps, predicts on each transfer
    always @(posedge clk or negedge rst_n)
    begin : event_driver
        psl_out_t look;
        int unsigned burst_left;
        int unsigned gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (strip_update(in_data, look))
                    look_q.push_back(look);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (event_q.size() != 0)
                begin
                    in_data <= event_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else if ($urandom_range(0, 7) == 0)
                            gap_left = $urandom_range(1, 20);
                        else
                            gap_left = $urandom_range(1, 3);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // look receiver: drives out_ready by a stall mode that is re-picked at random
    always @(posedge clk or negedge rst_n)
    begin : look_receiver
        int unsigned stall_cycle;
        int unsigned stall_mode;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_cycle = 0;
            stall_mode = 0;
        end
        else
        begin
            stall_cycle++;
            if (stall_cycle % 97 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= (stall_cycle % 5 == 0);
                default: out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // look checker: each transfer against the oldest prediction
    always @(posedge clk)
    begin : look_checker
        psl_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (look_q.size() == 0)
            begin
                $error("unexpected look: command %0d hue %0d sat %0d bright %0d power %0d",
                       out_data.command, out_data.hue, out_data.saturation,
                       out_data.brightness, out_data.power_on);
                mismatch_count++;
            end
            else
            begin
                want = look_q.pop_front();
                if (out_data.command !== want.command)
                begin
                    $error("command: expected %0d, got %0d", want.command, out_data.command);
                    mismatch_count++;
                end
                if (out_data.hue !== want.hue)
                begin
                    $error("hue: expected %0d, got %0d", want.hue, out_data.hue);
                    mismatch_count++;
                end
                if (out_data.saturation !== want.saturation)
                begin
                    $error("saturation: expected %0d, got %0d",
                           want.saturation, out_data.saturation);
                    mismatch_count++;
                end
                if (out_data.brightness !== want.brightness)
                begin
                    $error("brightness: expected %0d, got %0d",
                           want.brightness, out_data.brightness);
                    mismatch_count++;
                end
                if (out_data.power_on !== want.power_on)
                begin
                    $error("power_on: expected %0d, got %0d", want.power_on, out_data.power_on);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus sequence
    initial
    begin
        int unsigned s_crit;
        int unsigned s_low;
        int unsigned s_on;
        int unsigned s_lgap;
        int unsigned s_cgap;

        // power-up status and register defaults
        cfg_crit_pct = RST_CRITICAL_PERCENT;
        cfg_low_pct = RST_LOW_PERCENT;
        cfg_pulse_on = RST_PULSE_ON_MS;
        cfg_low_gap = RST_LOW_PERIOD_MS;
        cfg_crit_gap = RST_CRITICAL_PERIOD_MS;
        st_caps = 1'b0;
        st_mode = CHARGE_OK;
        st_active = 1'b1;
        st_override = 1'b0;
        st_saved_on = 1'b0;
        st_lit = 1'b0;
        st_armed = 1'b0;
        st_count = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: caps, low and critical pulses, zero dark gap, idle, restore
        apply_setting(10, 20, 2, 3, 0);
        push_event(KIND_LED_REPORT, 8'hFD, 7'd0, 1'b1, 1'b0);
        push_event(KIND_LED_REPORT, 8'h02, 7'd0, 1'b1, 1'b1);
        push_event(KIND_LED_REPORT, 8'hFF, 7'd0, 1'b1, 1'b0);
        push_event(KIND_BATTERY, 8'h00, 7'd20, 1'b1, 1'b0);
        push_event(KIND_TICK, 8'h00, 7'd0, 1'b1, 1'b0);
        push_event(KIND_TICK, 8'h00, 7'd0, 1'b1, 1'b0);
        push_event(KIND_TICK, 8'h00, 7'd0, 1'b1, 1'b0);
        push_event(KIND_BATTERY, 8'h00, 7'd10, 1'b1, 1'b0);
        push_event(KIND_TICK, 8'h00, 7'd0, 1'b1, 1'b0);
        push_event(KIND_TICK, 8'h00, 7'd0, 1'b1, 1'b0);
        push_event(KIND_TICK, 8'h00, 7'd0, 1'b1, 1'b0);
        push_event(KIND_TICK, 8'h00, 7'd0, 1'b1, 1'b0);
        push_event(KIND_ACTIVITY, 8'h00, 7'd0, 1'b0, 1'b0);
        push_event(KIND_TICK, 8'h00, 7'd0, 1'b0, 1'b0);
        push_event(KIND_ACTIVITY, 8'h00, 7'd0, 1'b1, 1'b0);
        push_event(KIND_BATTERY, 8'h00, 7'd100, 1'b1, 1'b0);
        push_event(KIND_LED_REPORT, 8'h00, 7'd0, 1'b1, 1'b0);
        push_event(KIND_BATTERY, 8'h00, 7'd0, 1'b1, 1'b0);
        push_event(KIND_TICK, 8'h00, 7'd0, 1'b1, 1'b1);
        push_event(KIND_BATTERY, 8'h00, 7'd21, 1'b1, 1'b1);
        push_event(KIND_ACTIVITY, 8'h00, 7'd0, 1'b1, 1'b0);
        push_event(KIND_ACTIVITY, 8'h00, 7'd0, 1'b0, 1'b0);
        push_event(KIND_BATTERY, 8'h00, 7'd15, 1'b0, 1'b1);
        push_event(KIND_ACTIVITY, 8'h00, 7'd0, 1'b1, 1'b1);
        push_event(KIND_TICK, 8'h00, 7'd0, 1'b1, 1'b0);
        wait_idle();

        // random phases, one register setting each
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    s_crit = 10; s_low = 20; s_on = 1; s_lgap = 1; s_cgap = 2;
                end
                1:
                begin
                    s_crit = 0; s_low = 100; s_on = 0; s_lgap = 0; s_cgap = 65535;
                end
                2:
                begin
                    s_crit = 100; s_low = 0; s_on = 65535; s_lgap = 3; s_cgap = 1;
                end
                3:
                begin
                    s_crit = $urandom_range(0, 100);
                    s_low = $urandom_range(0, 100);
                    s_on = $urandom_range(1, 4);
                    s_lgap = $urandom_range(0, 6);
                    s_cgap = $urandom_range(0, 6);
                end
                4:
                begin
                    s_crit = 50; s_low = 30; s_on = 3; s_lgap = 5; s_cgap = 4;
                end
                default:
                begin
                    s_crit = 30; s_low = 60; s_on = 2; s_lgap = 65535; s_cgap = 2;
                end
            endcase
            apply_setting(s_crit, s_low, s_on, s_lgap, s_cgap);
            repeat (258) event_q.push_back(random_event());
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- priority_status_led_pulser_core.f -----
+incdir+design
design/psl_pkg.sv
design/priority_status_led_pulser_core.sv
tb/tb_top.sv
